### rtl/core/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and sizing constants for the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  // fixed field widths
  localparam int ADDR_W = 24;
  localparam int SIZE_W = 25;
  // wide enough for address + size - 1 and for frame end indexes
  localparam int SUM_W  = 26;

  // store geometry, both powers of two
  localparam int NUM_FRAMES  = 4096;
  localparam int BLOCK_SIZE  = 4096;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_SIZE);

  // map is kept as rows of WORD_BITS frames, at least two rows
  localparam int WORD_BITS = (NUM_FRAMES >= 128) ? 64 : NUM_FRAMES / 2;
  localparam int NUM_WORDS = NUM_FRAMES / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ROW_W     = $clog2(NUM_WORDS);
  localparam int FRAME_W   = ROW_W + BIT_W;

  // operation codes
  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE      = 2'd1,
    OP_MARK_FREE = 2'd2,
    OP_MARK_USED = 2'd3
  } fba_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PRIME,
    ST_SCAN,
    ST_FIX_RD,
    ST_FIX_WR,
    ST_DONE
  } fba_state_t;

endpackage

### rtl/core/fba_ifs.sv
// ----------------------------------------------------------------------------
// fba channel interfaces
// Valid/ready request and response channels of the frame bitmap allocator.
// ----------------------------------------------------------------------------
interface fba_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [fba_pkg::ADDR_W-1:0] address;
  logic [fba_pkg::SIZE_W-1:0] region_size;

  modport source (output valid, operation, address, region_size, input ready);
  modport sink   (input valid, operation, address, region_size, output ready);
endinterface

interface fba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [fba_pkg::ADDR_W-1:0] frame_address;

  modport source (output valid, status, frame_address, input ready);
  modport sink   (input valid, status, frame_address, output ready);
endinterface

### rtl/core/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// One used/free bit per physical frame, with allocate, free and region marks.
// ----------------------------------------------------------------------------
// The map lives in a simple dual-port memory of NUM_WORDS rows of WORD_BITS
// bits (64 x 64 by default), one row read and one row written per cycle; a
// small sequencer walks the rows. A request word is taken only while the
// sequencer is idle. Allocate scans rows from row 0 and stops at the first
// row with a free frame, or at the last row when the map is full. Free walks
// the one row that holds its frame and mark-used walks every row the range
// touches; mark-free does the same and then re-reserves frame 0 with a read
// and a write of row 0. An empty or out-of-store range skips the walk, but
// mark-free still re-reserves frame 0. The sequencer then returns to idle
// before the next request word can be taken.
// Reset needs no clearing pass: each row has a valid bit that reads an
// unwritten row as all used. A finished response word waits in an output
// register, so the next request word can be taken while it is pending.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator (
  input  logic          clk,
  input  logic          rst,
  fba_req_if.sink       req,
  fba_rsp_if.source     rsp
);
  import fba_pkg::*;

  // sequencer and request registers
  fba_state_t          state, state_next;
  logic [1:0]          op, op_next;
  logic [ADDR_W-1:0]   base_addr, base_addr_next;
  logic [SUM_W-1:0]    span, span_next;
  logic                size_zero, size_zero_next;
  logic [FRAME_W-1:0]  first_frame, first_frame_next;
  logic [FRAME_W:0]    end_frame, end_frame_next;
  logic [FRAME_W-1:0]  last_frame, last_frame_next;
  logic [ROW_W-1:0]    cur_row, cur_row_next;
  logic                res_status, res_status_next;
  logic [ADDR_W-1:0]   res_addr, res_addr_next;

  // output register
  logic                out_valid, out_valid_next;
  logic                out_status, out_status_next;
  logic [ADDR_W-1:0]   out_addr, out_addr_next;

  // map memory
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_hit;
  logic [ROW_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [ROW_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // datapath helpers
  logic [WORD_BITS-1:0]   word;
  logic [WORD_BITS-1:0]   inv;
  logic [WORD_BITS-1:0]   onehot;
  logic                   any_free;
  logic [BIT_W-1:0]       free_bit;
  logic [FRAME_W+ADDR_W-1:0] alloc_wide;
  logic [ROW_W-1:0]       first_row;
  logic [ROW_W-1:0]       last_row;
  logic                   is_first;
  logic                   is_last;
  logic [BIT_W-1:0]       lo_bit;
  logic [BIT_W-1:0]       hi_bit;
  logic [WORD_BITS-1:0]   range_mask;
  logic [SUM_W-1:0]       first_w;
  logic [SUM_W-1:0]       count_w;
  logic [SUM_W:0]         end_w;
  logic                   range_empty;
  logic [FRAME_W:0]       end_clip;

  // memory: registered read, row valid bits
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_hit <= row_valid[rd_addr];
    end
  end

  // unwritten rows read as all used
  assign word = rd_hit ? rd_data : '1;

  // lowest free frame in the current row
  assign inv      = ~word;
  assign onehot   = inv & (~inv + 1'b1);
  assign any_free = |inv;

  always_comb begin
    free_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      free_bit = free_bit | (onehot[i] ? BIT_W'(i) : '0);
    end
  end

  assign alloc_wide = {{ADDR_W{1'b0}}, cur_row, free_bit} << BLOCK_SHIFT;

  // bits of the current row inside the range
  assign first_row  = first_frame[FRAME_W-1:BIT_W];
  assign last_row   = last_frame[FRAME_W-1:BIT_W];
  assign is_first   = (cur_row == first_row);
  assign is_last    = (cur_row == last_row);
  assign lo_bit     = is_first ? first_frame[BIT_W-1:0] : '0;
  assign hi_bit     = is_last  ? last_frame[BIT_W-1:0]  : '1;
  assign range_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (~hi_bit));

  // frame range from base and span, clipped to the store
  assign first_w = SUM_W'(base_addr) >> BLOCK_SHIFT;
  assign count_w = span >> BLOCK_SHIFT;
  assign end_w   = (op == OP_MARK_USED) ? ({1'b0, count_w} + 1'b1)
                                        : ({1'b0, first_w} + {1'b0, count_w});
  assign range_empty = ((op == OP_MARK_USED) && size_zero)
                    || ({1'b0, first_w} >= (SUM_W+1)'(NUM_FRAMES))
                    || (end_w <= {1'b0, first_w});
  assign end_clip = (end_w > (SUM_W+1)'(NUM_FRAMES)) ? (FRAME_W+1)'(NUM_FRAMES)
                                                     : end_w[FRAME_W:0];

  // next state and outputs
  always_comb begin
    state_next       = state;
    op_next          = op;
    base_addr_next   = base_addr;
    span_next        = span;
    size_zero_next   = size_zero;
    first_frame_next = first_frame;
    end_frame_next   = end_frame;
    last_frame_next  = last_frame;
    cur_row_next     = cur_row;
    res_status_next  = res_status;
    res_addr_next    = res_addr;
    out_valid_next   = out_valid && !rsp.ready;
    out_status_next  = out_status;
    out_addr_next    = out_addr;
    rd_addr          = cur_row + 1'b1;
    wr_en            = 1'b0;
    wr_addr          = cur_row;
    wr_data          = word;
    req.ready        = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          op_next        = req.operation;
          base_addr_next = req.address;
          size_zero_next = (req.region_size == '0);
          priority case (req.operation)
            OP_MARK_USED: span_next = SUM_W'(req.address) + SUM_W'(req.region_size) - 1'b1;
            OP_FREE:      span_next = SUM_W'(BLOCK_SIZE);
            default:      span_next = SUM_W'(req.region_size);
          endcase
          res_status_next = 1'b0;
          res_addr_next   = '0;
          state_next      = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (op == OP_ALLOC) begin
          first_frame_next = '0;
          end_frame_next   = (FRAME_W+1)'(NUM_FRAMES);
          state_next       = ST_PRIME;
        end else begin
          first_frame_next = first_w[FRAME_W-1:0];
          end_frame_next   = end_clip;
          if (!range_empty) begin
            state_next = ST_PRIME;
          end else if (op == OP_MARK_FREE) begin
            state_next = ST_FIX_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_PRIME: begin
        rd_addr         = first_row;
        last_frame_next = FRAME_W'(end_frame - 1'b1);
        cur_row_next    = first_row;
        state_next      = ST_SCAN;
      end
      ST_SCAN: begin
        if (op == OP_ALLOC) begin
          if (any_free) begin
            wr_en           = 1'b1;
            wr_data         = word | onehot;
            res_addr_next   = alloc_wide[ADDR_W-1:0];
            state_next      = ST_DONE;
          end else if (is_last) begin
            res_status_next = 1'b1;
            state_next      = ST_DONE;
          end else begin
            cur_row_next    = cur_row + 1'b1;
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = (op == OP_MARK_USED) ? (word | range_mask) : (word & ~range_mask);
          if (!is_last) begin
            cur_row_next = cur_row + 1'b1;
          end else if (op == OP_MARK_FREE) begin
            state_next = ST_FIX_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FIX_RD: begin
        // frame 0 stays reserved after a mark-free
        rd_addr      = '0;
        cur_row_next = '0;
        state_next   = ST_FIX_WR;
      end
      ST_FIX_WR: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = word | WORD_BITS'(1);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_addr_next   = res_addr;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op          <= op_next;
    base_addr   <= base_addr_next;
    span        <= span_next;
    size_zero   <= size_zero_next;
    first_frame <= first_frame_next;
    end_frame   <= end_frame_next;
    last_frame  <= last_frame_next;
    cur_row     <= cur_row_next;
    res_status  <= res_status_next;
    res_addr    <= res_addr_next;
    out_status  <= out_status_next;
    out_addr    <= out_addr_next;
  end

  // response word
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.frame_address = out_addr;

endmodule

### rtl/core/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks on the frame bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_status,
  input logic [fba_pkg::ADDR_W-1:0] rsp_frame_address
);
  import fba_pkg::*;

  // a pending response word holds until taken
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_frame_address))
    else $error("response word changed while stalled");

  // a failed allocation never reports an address
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_frame_address == '0)
    else $error("failure status with nonzero address");

  // the sequencer is busy right after taking a request word
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken back to back");

  // no response word straight out of reset
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_frame_address (rsp.frame_address)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free and region-mark words into the frame bitmap
// allocator and checks every reply against a bit map kept alongside it.
// A directed table covers the empty and full map, frame zero and ranges past
// the store, then random words run under three idle patterns, with one long
// reply hold-off that backs the request channel up.
// ----------------------------------------------------------------------------
module testbench;
  import fba_pkg::*;

  localparam int RAND_PER_PHASE = 667;
  localparam int DIRECTED_ROWS  = 24;
  localparam int HOLD_AFTER     = 1400;
  localparam int HOLD_CYCLES    = 600;
  localparam int PRINT_CAP      = 200;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] frame_address;
  } reply_t;

  typedef struct packed {
    fba_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              typed;
    logic              status;
    logic [ADDR_W-1:0] frame_address;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  fba_req_if req_ch ();
  fba_rsp_if rsp_ch ();

  frame_bitmap_allocator uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow of the used/free map, 1 = used
  bit     frame_used [NUM_FRAMES];
  reply_t replies_due [$];
  int     mismatch_count = 0;
  int     send_idle_pct;
  int     recv_idle_pct;

  // directed words: reply typed in where it is obvious, else from the shadow map
  step_row_t directed_steps [DIRECTED_ROWS] = '{
    // map full out of reset
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b1, 1'b1, 24'h000000},
    // frame zero freed explicitly can be allocated
    '{OP_FREE,      24'h000000, 25'h0000000, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b1, 1'b1, 24'h000000},
    // whole store freed, frame zero re-reserved
    '{OP_MARK_FREE, 24'h000000, 25'h1000000, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'hFFFFFF, 25'h1FFFFFF, 1'b0, 1'b0, 24'h000000},
    // last byte of the store
    '{OP_MARK_USED, 24'hFFFFFF, 25'h0000001, 1'b1, 1'b0, 24'h000000},
    // unaligned base with aligned size touches two frames
    '{OP_MARK_USED, 24'h001800, 25'h0001000, 1'b1, 1'b0, 24'h000000},
    // zero size touches nothing
    '{OP_MARK_USED, 24'h005000, 25'h0000000, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b0, 1'b0, 24'h000000},
    // range running past the store
    '{OP_MARK_FREE, 24'hFFF000, 25'h1FFFFFF, 1'b1, 1'b0, 24'h000000},
    '{OP_FREE,      24'hFFFFFF, 25'h1FFFFFF, 1'b1, 1'b0, 24'h000000},
    // fill everything, then allocation runs out
    '{OP_MARK_USED, 24'h000000, 25'h1FFFFFF, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b1, 1'b1, 24'h000000},
    // mark-free with a size under one frame frees nothing
    '{OP_MARK_FREE, 24'h003000, 25'h0000FFF, 1'b1, 1'b0, 24'h000000},
    '{OP_FREE,      24'h000FFF, 25'h0000000, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b1, 1'b0, 24'h000000},
    '{OP_MARK_FREE, 24'h800000, 25'h0001000, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b0, 1'b0, 24'h000000},
    '{OP_MARK_USED, 24'hFFFFFF, 25'h1FFFFFF, 1'b1, 1'b0, 24'h000000},
    // unaligned base on mark free
    '{OP_MARK_FREE, 24'h000ABC, 25'h0003000, 1'b1, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b0, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b0, 1'b0, 24'h000000},
    '{OP_ALLOC,     24'h000000, 25'h0000000, 1'b0, 1'b0, 24'h000000}
  };

  // apply one operation to the shadow map and return its reply
  function automatic reply_t apply_frame_op(fba_op_t op, logic [ADDR_W-1:0] addr,
                                            logic [SIZE_W-1:0] size);
    reply_t           r;
    int               first;
    int               last;
    int               count;
    int               f;
    logic [SUM_W-1:0] tail;
    r     = '0;
    first = int'(addr >> BLOCK_SHIFT);
    case (op)
      OP_ALLOC: begin
        r.status = 1'b1;
        for (f = 0; f < NUM_FRAMES && r.status; f++) begin
          if (!frame_used[f]) begin
            frame_used[f]   = 1'b1;
            r.status        = 1'b0;
            r.frame_address = ADDR_W'(f * BLOCK_SIZE);
          end
        end
      end
      OP_FREE: begin
        if (first < NUM_FRAMES) frame_used[first] = 1'b0;
      end
      OP_MARK_FREE: begin
        count = int'(size >> BLOCK_SHIFT);
        for (f = first; f < first + count && f < NUM_FRAMES; f++) frame_used[f] = 1'b0;
        frame_used[0] = 1'b1;
      end
      OP_MARK_USED: begin
        if (size != '0) begin
          tail = SUM_W'(addr) + SUM_W'(size) - SUM_W'(1);
          last = int'(tail >> BLOCK_SHIFT);
          for (f = first; f <= last && f < NUM_FRAMES; f++) frame_used[f] = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // offer one request word, then book its reply once it is taken
  task automatic issue_request(fba_op_t op, logic [ADDR_W-1:0] addr,
                               logic [SIZE_W-1:0] size, logic typed, reply_t typed_reply);
    reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.address     <= addr;
    req_ch.region_size <= size;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_frame_op(op, addr, size);
    replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  // base address mostly in the low rows so allocation scans vary in depth
  function automatic logic [ADDR_W-1:0] pick_base();
    int frame;
    if ($urandom_range(99) < 20) return ADDR_W'($urandom);
    frame = ($urandom_range(99) < 60) ? $urandom_range(0, 127)
                                      : $urandom_range(0, NUM_FRAMES - 1);
    return ADDR_W'((frame << BLOCK_SHIFT) | $urandom_range(0, BLOCK_SIZE - 1));
  endfunction

  // region length, mostly a few frames
  function automatic logic [SIZE_W-1:0] pick_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 70)
      return SIZE_W'(($urandom_range(0, 8) << BLOCK_SHIFT) +
                     ($urandom_range(1) ? $urandom_range(0, BLOCK_SIZE - 1) : 0));
    if (pick < 90) return SIZE_W'($urandom_range(0, 32'h1FFFFFF));
    return $urandom_range(1) ? 25'h1000000 : 25'h1FFFFFF;
  endfunction

  // one random request word
  task automatic issue_random();
    int                pick;
    fba_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    pick = $urandom_range(99);
    addr = pick_base();
    size = pick_length();
    if (pick < 40) begin
      op   = OP_ALLOC;
      addr = ADDR_W'($urandom);
      size = SIZE_W'($urandom);
    end else if (pick < 60) begin
      op = OP_FREE;
    end else if (pick < 75) begin
      op = OP_MARK_FREE;
    end else if (pick < 97) begin
      op = OP_MARK_USED;
    end else begin
      // fill the store so allocation runs dry now and then
      op   = OP_MARK_USED;
      addr = ADDR_W'($urandom_range(0, BLOCK_SIZE - 1));
      size = 25'h1FFFFFF;
    end
    issue_request(op, addr, size, 1'b0, '0);
  endtask

  // reply side: random back-pressure and one long hold-off
  initial begin
    int  taken;
    bit  held;
    taken        = 0;
    held         = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) taken++;
      if (taken == HOLD_AFTER && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each reply word with the oldest one due
  always @(posedge clk) begin
    reply_t due;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected reply", {7'd0, rsp_ch.status, rsp_ch.frame_address}, 0);
      end else begin
        due = replies_due.pop_front();
        if (rsp_ch.status !== due.status)
          report_mismatch("status", rsp_ch.status, due.status);
        if (rsp_ch.frame_address !== due.frame_address)
          report_mismatch("frame_address", rsp_ch.frame_address, due.frame_address);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int i;
    int phase;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_ALLOC;
    req_ch.address     = '0;
    req_ch.region_size = '0;
    send_idle_pct      = 17;
    recv_idle_pct      = 76;
    for (i = 0; i < NUM_FRAMES; i++) frame_used[i] = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < DIRECTED_ROWS; i++)
      issue_request(directed_steps[i].op, directed_steps[i].addr, directed_steps[i].size,
                    directed_steps[i].typed,
                    '{directed_steps[i].status, directed_steps[i].frame_address});

    // random words under three idle patterns
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 17 : 0;
      for (i = 0; i < RAND_PER_PHASE; i++) issue_random();
    end
    req_ch.valid <= 1'b0;

    // drain, then give a stray reply time to show up
    while (replies_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
